// ===== design/urt_pkg.sv =====
// Shared types and constants of the ultrasonic range trigger.
package urt_pkg;

    localparam int TICK_W = 16;
    localparam int COOL_W = 26;
    localparam int DIST_W = 13;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 26;

    // Width to tenths of a centimetre: (w * SCALE_MUL + SCALE_RND) >> SCALE_SHIFT
    localparam int SCALE_MUL_W = 14;
    localparam int PROD_W = TICK_W + SCALE_MUL_W;
    localparam int SCALE_SHIFT = 16;
    localparam int RAW_W = PROD_W - SCALE_SHIFT;
    localparam logic [SCALE_MUL_W-1:0] SCALE_MUL = 14'd11239;
    localparam logic [PROD_W-1:0] SCALE_RND = 30'd32768;
    localparam logic [DIST_W-1:0] DIST_MAX = 13'd8191;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_DIST = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DIST = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 3'd3;

    localparam logic [DIST_W-1:0] RST_MIN_DIST = 13'd20;
    localparam logic [DIST_W-1:0] RST_MAX_DIST = 13'd500;
    localparam logic [COOL_W-1:0] RST_COOLDOWN = 26'd5000000;
    localparam logic [TICK_W-1:0] RST_TIMEOUT = 16'd40000;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_TRIG = 3'd1,
        PH_RISE = 3'd2,
        PH_MEAS = 3'd3
    } t_phase;

    typedef struct packed {
        logic [DIST_W-1:0] min_dist;
        logic [DIST_W-1:0] max_dist;
        logic [COOL_W-1:0] cooldown;
        logic [TICK_W-1:0] timeout;
    } t_cfg;

    typedef struct packed {
        t_phase            phase;
        logic [TICK_W-1:0] phase_ticks;
        logic [COOL_W-1:0] cooldown_left;
    } t_state;

    typedef struct packed {
        logic              trigger_level;
        logic              measure_done;
        logic [DIST_W-1:0] distance_tenths;
        logic              timed_out;
        logic              detected;
        logic              ready_res;
    } t_result;

endpackage

// ===== design/urt_cfg.sv =====
// Configuration register file of the ultrasonic range trigger.
module urt_cfg import urt_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_dist <= RST_MIN_DIST;
            r_cfg.max_dist <= RST_MAX_DIST;
            r_cfg.cooldown <= RST_COOLDOWN;
            r_cfg.timeout  <= RST_TIMEOUT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_MIN_DIST: r_cfg.min_dist <= i_cfg_data[DIST_W-1:0];
                REG_MAX_DIST: r_cfg.max_dist <= i_cfg_data[DIST_W-1:0];
                REG_COOLDOWN: r_cfg.cooldown <= i_cfg_data[COOL_W-1:0];
                REG_TIMEOUT:  r_cfg.timeout  <= i_cfg_data[TICK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== design/urt_step.sv =====
// Per-tick next-state and result logic of the ultrasonic range trigger.
module urt_step import urt_pkg::*; #(
    parameter int TRIGGER_TICKS = 10
) (
    input  t_state  i_state,
    input  t_cfg    i_cfg,
    input  logic    i_req,
    input  logic    i_echo,
    output t_state  o_state,
    output t_result o_res
);

    localparam logic [TICK_W-1:0] TRIG_LAST = TICK_W'(TRIGGER_TICKS);

    logic [COOL_W-1:0] cool_dec;
    logic [TICK_W-1:0] ticks_inc;
    logic [PROD_W-1:0] prod;
    logic [RAW_W-1:0]  raw;
    logic              finish;
    t_state            nxt;
    t_result           res;

    always_comb begin
        cool_dec  = (i_state.cooldown_left != '0) ? i_state.cooldown_left - 1'b1
                                                  : i_state.cooldown_left;
        ticks_inc = i_state.phase_ticks + 1'b1;
        prod      = PROD_W'(i_state.phase_ticks) * PROD_W'(SCALE_MUL) + SCALE_RND;
        raw       = prod[PROD_W-1:SCALE_SHIFT];

        nxt = i_state;
        nxt.cooldown_left = cool_dec;
        res = '0;
        finish = 1'b0;

        case (i_state.phase)
            PH_IDLE: begin
                if (i_req && cool_dec == '0) begin
                    res.trigger_level = 1'b1;
                    if (TICK_W'(1) >= TRIG_LAST) begin
                        nxt.phase = PH_RISE;
                        nxt.phase_ticks = '0;
                    end else begin
                        nxt.phase = PH_TRIG;
                        nxt.phase_ticks = TICK_W'(1);
                    end
                end
            end
            PH_TRIG: begin
                res.trigger_level = 1'b1;
                nxt.phase_ticks = ticks_inc;
                if (ticks_inc >= TRIG_LAST) begin
                    nxt.phase = PH_RISE;
                    nxt.phase_ticks = '0;
                end
            end
            PH_RISE: begin
                if (i_echo) begin
                    nxt.phase = PH_MEAS;
                    nxt.phase_ticks = TICK_W'(1);
                end else if (i_state.phase_ticks >= i_cfg.timeout) begin
                    res.timed_out = 1'b1;
                    finish = 1'b1;
                end else begin
                    nxt.phase_ticks = ticks_inc;
                end
            end
            PH_MEAS: begin
                if (i_echo) begin
                    if (i_state.phase_ticks >= i_cfg.timeout) begin
                        res.timed_out = 1'b1;
                        finish = 1'b1;
                    end else begin
                        nxt.phase_ticks = ticks_inc;
                    end
                end else begin
                    // Saturate the output only; the window test sees the raw value.
                    res.distance_tenths = (raw > RAW_W'(DIST_MAX)) ? DIST_MAX
                                                                   : raw[DIST_W-1:0];
                    if (RAW_W'(i_cfg.min_dist) <= raw && raw <= RAW_W'(i_cfg.max_dist)) begin
                        res.detected = 1'b1;
                        nxt.cooldown_left = i_cfg.cooldown;
                    end
                    finish = 1'b1;
                end
            end
            default: begin
                nxt.phase = PH_IDLE;
                nxt.phase_ticks = '0;
            end
        endcase

        if (finish) begin
            res.measure_done = 1'b1;
            nxt.phase = PH_IDLE;
            nxt.phase_ticks = '0;
        end

        res.ready_res = (nxt.phase == PH_IDLE) && (nxt.cooldown_left == '0);
    end

    assign o_state = nxt;
    assign o_res   = res;

endmodule

// ===== design/ultrasonic_range_trigger.sv =====
// Top level of the ultrasonic range trigger: state, result register and handshake.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-----------------------------------------
//   in      | in        | i_in_valid / o_in_stall | i_start_request, i_echo_level
//   out     | out       | o_out_valid/i_out_stall | o_trigger_level, o_measure_done,
//           |           |                         | o_distance_tenths, o_timed_out,
//           |           |                         | o_detected, o_ready_res
//   cfg     | in        | i_cfg_we                | i_cfg_index, i_cfg_data
//
// One tick per cycle while the input is not stalled: a transfer on the input updates the phase
// state and loads the result register in the same clock, so the result appears in the cycle after.
// The path is the echo width multiply (16 x 14 bits) followed by the window compare.
// Input stalls only while a result sits in the output register and the sink stalls;
// a result taken in the same cycle frees the register for the next transfer.
// Synchronous reset returns to idle with no cooldown and the default registers.
module ultrasonic_range_trigger import urt_pkg::*; #(
    parameter int TRIGGER_TICKS = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_start_request,
    input  logic                  i_echo_level,
    // output channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_trigger_level,
    output logic                  o_measure_done,
    output logic [DIST_W-1:0]     o_distance_tenths,
    output logic                  o_timed_out,
    output logic                  o_detected,
    output logic                  o_ready_res,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg    cfg;
    t_state  r_state;
    t_state  n_state;
    t_result r_res;
    t_result n_res;
    logic    r_out_valid;
    logic    in_fire;

    urt_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    urt_step #(
        .TRIGGER_TICKS (TRIGGER_TICKS)
    ) u_step (
        .i_state (r_state),
        .i_cfg   (cfg),
        .i_req   (i_start_request),
        .i_echo  (i_echo_level),
        .o_state (n_state),
        .o_res   (n_res)
    );

    // Hold the input off only while the waiting result cannot leave.
    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_fire    = i_in_valid && !o_in_stall;

    // Advance the phase state once per accepted tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase         <= PH_IDLE;
            r_state.phase_ticks   <= '0;
            r_state.cooldown_left <= '0;
        end else if (in_fire) begin
            r_state <= n_state;
        end
    end

    // Result register: load on a transfer in, drop valid once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_trigger_level   = r_res.trigger_level;
    assign o_measure_done    = r_res.measure_done;
    assign o_distance_tenths = r_res.distance_tenths;
    assign o_timed_out       = r_res.timed_out;
    assign o_detected        = r_res.detected;
    assign o_ready_res       = r_res.ready_res;

endmodule

// ===== design/urt_checker.sv =====
// Port-level checks of the ultrasonic range trigger, bound to the top level.
module urt_checker import urt_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_in_stall,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input logic                  o_trigger_level,
    input logic                  o_measure_done,
    input logic [DIST_W-1:0]     o_distance_tenths,
    input logic                  o_timed_out,
    input logic                  o_detected
);

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_distance_tenths)
            && $stable(o_measure_done) && $stable(o_detected))
        else $error("stalled result changed");

    // Input stalls only behind a waiting result.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled with no result waiting");

    // Trigger pulse never coincides with the end of a measurement.
    a_done_no_trig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_measure_done |-> !o_trigger_level)
        else $error("trigger high on measurement end");

    // Timeout carries no distance and no detection.
    a_timeout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_timed_out |->
            o_measure_done && o_distance_tenths == '0 && !o_detected)
        else $error("timeout result malformed");

    // Detection only at the end of a measurement.
    a_detect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_detected |-> o_measure_done)
        else $error("detection without measurement end");

endmodule

bind ultrasonic_range_trigger urt_checker u_urt_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_in_stall        (o_in_stall),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_trigger_level   (o_trigger_level),
    .o_measure_done    (o_measure_done),
    .o_distance_tenths (o_distance_tenths),
    .o_timed_out       (o_timed_out),
    .o_detected        (o_detected)
);
